/* rtl/core/cdq_pkg.sv */
// Shared types, constants and pointer helpers for the circular deque.
package cdq_pkg;

  // Physical depth of the word store.
  localparam int DEPTH  = 16;
  // Largest usable slot count: the store depth, capped so the count fits in four bits.
  localparam int CAP    = (DEPTH < 16) ? DEPTH : 16;
  localparam int PTR_W  = $clog2(CAP);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 4;
  localparam int DATA_W = 32;

  localparam logic [SLOT_W-1:0] SLOTS_RESET = SLOT_W'(16);
  localparam logic [SLOT_W-1:0] SLOTS_MIN   = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOTS_CAP   = SLOT_W'(CAP);
  localparam logic signed [DATA_W-1:0] DATA_NONE = '1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slots_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ACT_PUSH_REAR  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Decision for the beat on the input channel, from the pointer unit to the top level.
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    ptr_t    addr;
    status_t status;
    cnt_t    count;
  } op_t;

  function automatic ptr_t wrap_inc(ptr_t i, slots_t n);
    slots_t s;
    s = SLOT_W'(i) + SLOT_W'(1);
    return (s == n) ? '0 : PTR_W'(s);
  endfunction

  function automatic ptr_t wrap_dec(ptr_t i, slots_t n);
    slots_t s;
    s = n - SLOT_W'(1);
    return (i == '0) ? PTR_W'(s) : ptr_t'(i - 1'b1);
  endfunction

  function automatic cnt_t fill_count(ptr_t f, ptr_t r, slots_t n);
    slots_t fe;
    slots_t re;
    slots_t d;
    fe = SLOT_W'(f);
    re = SLOT_W'(r);
    d  = (re >= fe) ? (re - fe) : (re + n - fe);
    return CNT_W'(d);
  endfunction

endpackage

/* rtl/core/cdq_ram.sv */
// Generic single-port synchronous RAM with a registered read.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/cdq_ptr.sv */
// Front and rear pointers, slot count register and the per-beat push or pop decision.
module cdq_ptr (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  cdq_pkg::slots_t        cfg_data,
  input  logic                   accept,
  input  cdq_pkg::action_t       action,
  output cdq_pkg::op_t           op
);

  cdq_pkg::ptr_t   front_r, front_nxt;
  cdq_pkg::ptr_t   rear_r, rear_nxt;
  cdq_pkg::slots_t slots_r;
  cdq_pkg::slots_t n;
  cdq_pkg::ptr_t   rear_inc;
  cdq_pkg::ptr_t   front_inc;
  logic            full;
  logic            empty;

  // Effective slot count, clamped to the usable range.
  always_comb begin
    if (slots_r < cdq_pkg::SLOTS_MIN) begin
      n = cdq_pkg::SLOTS_MIN;
    end else if (slots_r > cdq_pkg::SLOTS_CAP) begin
      n = cdq_pkg::SLOTS_CAP;
    end else begin
      n = slots_r;
    end
  end

  assign rear_inc  = cdq_pkg::wrap_inc(rear_r, n);
  assign front_inc = cdq_pkg::wrap_inc(front_r, n);
  assign full      = (rear_inc == front_r);
  assign empty     = (front_r == rear_r);

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    op.wr_en  = 1'b0;
    op.rd_en  = 1'b0;
    op.addr   = rear_r;
    op.status = cdq_pkg::ST_DONE;
    unique case (action)
      cdq_pkg::ACT_PUSH_REAR: begin
        if (full) begin
          op.status = cdq_pkg::ST_FULL;
        end else begin
          rear_nxt = rear_inc;
          op.wr_en = 1'b1;
          op.addr  = rear_inc;
        end
      end
      cdq_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          op.status = cdq_pkg::ST_FULL;
        end else begin
          front_nxt = cdq_pkg::wrap_dec(front_r, n);
          op.wr_en  = 1'b1;
          op.addr   = front_r;
        end
      end
      cdq_pkg::ACT_POP_FRONT: begin
        if (empty) begin
          op.status = cdq_pkg::ST_EMPTY;
        end else begin
          front_nxt = front_inc;
          op.rd_en  = 1'b1;
          op.addr   = front_inc;
        end
      end
      cdq_pkg::ACT_POP_REAR: begin
        if (empty) begin
          op.status = cdq_pkg::ST_EMPTY;
        end else begin
          rear_nxt = cdq_pkg::wrap_dec(rear_r, n);
          op.rd_en = 1'b1;
          op.addr  = rear_r;
        end
      end
      default: begin
        op.status = cdq_pkg::ST_DONE;
      end
    endcase
    op.count = cdq_pkg::fill_count(front_nxt, rear_nxt, n);
  end

  // A slot count write empties the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      slots_r <= cdq_pkg::SLOTS_RESET;
    end else if (cfg_we) begin
      front_r <= '0;
      rear_r  <= '0;
      slots_r <= cfg_data;
    end else if (accept) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
  end

endmodule

/* rtl/core/circular_deque.sv */
// Top level of the circular deque: handshake control, result register and store.
//
// A double-ended queue of signed 32-bit words held in a circular store of
// cfg_data slots (clamped to 2..16, reset 16); one slot always stays empty,
// so at most slots minus one words are held. Each input beat pushes at the
// rear or front or pops from the front or rear, and yields exactly one
// result beat with the popped word (-1 for pushes and refused pops), a
// status (done, full, empty) and the word count after the operation. A
// push or a refused pop loads the result register directly; a successful
// pop waits in the read state for the word from the synchronous store with
// its registered read. A result waiting in the output register does not
// block the next input beat as long as the output side takes it in the same
// cycle. Writing the slot count empties the queue and must only be done
// while no beat is in flight.
module circular_deque (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cdq_pkg::SLOT_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic signed [cdq_pkg::DATA_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cdq_pkg::DATA_W-1:0]  out_data,
  output logic [1:0]                         out_status,
  output logic [cdq_pkg::CNT_W-1:0]          out_count
);

  cdq_pkg::state_t state_r, state_nxt;
  cdq_pkg::op_t    op;
  logic            accept;
  logic            out_busy;
  logic            load;
  logic            out_valid_r, out_valid_nxt;
  logic signed [cdq_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  cdq_pkg::status_t out_status_r, out_status_nxt;
  cdq_pkg::cnt_t    out_count_r, out_count_nxt;
  cdq_pkg::cnt_t    pend_count_r, pend_count_nxt;
  logic [cdq_pkg::DATA_W-1:0] rd_data;

  // The output register is busy when it holds a beat that is not taken now.
  assign out_busy = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  cdq_ptr u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .action   (cdq_pkg::action_t'(in_action)),
    .op       (op)
  );

  // The store is only touched on an accepted beat, so a write and a later read
  // of the same slot never overlap and need no forwarding.
  cdq_ram #(
    .WIDTH (cdq_pkg::DATA_W),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && op.wr_en),
    .re    (accept && op.rd_en),
    .addr  (cdq_pkg::ADDR_W'(op.addr)),
    .wdata (in_value),
    .rdata (rd_data)
  );

  // Next state, handshake and result register loading.
  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    load           = 1'b0;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    pend_count_nxt = pend_count_r;
    unique case (state_r)
      cdq_pkg::S_IDLE: begin
        in_stall = out_busy;
        if (in_valid && !out_busy) begin
          if (op.rd_en) begin
            // Successful pop: go to the read state to wait for the stored word.
            state_nxt      = cdq_pkg::S_READ;
            pend_count_nxt = op.count;
          end else begin
            load           = 1'b1;
            out_data_nxt   = cdq_pkg::DATA_NONE;
            out_status_nxt = op.status;
            out_count_nxt  = op.count;
          end
        end
      end
      cdq_pkg::S_READ: begin
        in_stall = 1'b1;
        if (!out_busy) begin
          load           = 1'b1;
          out_data_nxt   = rd_data;
          out_status_nxt = cdq_pkg::ST_DONE;
          out_count_nxt  = pend_count_r;
          state_nxt      = cdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cdq_pkg::S_IDLE;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    pend_count_r <= pend_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

/* sim/tb_circular_deque.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the circular deque, with its own behavioural mirror of the queue.
module tb_circular_deque;

  // Cycles without any beat on either channel, while work is outstanding, before the run is
  // abandoned.
  localparam int WATCHDOG_LIMIT = 5000;
  // Length of the deliberate hold-off on the result channel, in cycles.
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 12;
  localparam int OPS_PER_PHASE  = 140;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    cdq_pkg::action_t                   act;
    logic signed [cdq_pkg::DATA_W-1:0]  val;
  } deque_op_t;

  typedef struct {
    logic signed [cdq_pkg::DATA_W-1:0]  data;
    cdq_pkg::status_t                   status;
    cdq_pkg::cnt_t                      count;
  } deque_res_t;

  // Every input of the block starts at a known value.
  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               cfg_we    = 1'b0;
  logic [cdq_pkg::SLOT_W-1:0]         cfg_data  = '0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  logic [1:0]                         in_action = '0;
  logic signed [cdq_pkg::DATA_W-1:0]  in_value  = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [cdq_pkg::DATA_W-1:0]  out_data;
  logic [1:0]                         out_status;
  logic [cdq_pkg::CNT_W-1:0]          out_count;

  // Operations waiting to be offered, and the results owed by the block in arrival order.
  deque_op_t   queued_ops[$];
  deque_res_t  owed_results[$];
  deque_op_t   offered_op;

  // Mirror of the deque: word store, both pointers and the slot register.
  logic [cdq_pkg::DATA_W-1:0]  mirror_words [cdq_pkg::DEPTH];
  int unsigned                 mirror_front;
  int unsigned                 mirror_rear;
  int unsigned                 mirror_slots;

  // Idling rates in percent, the long hold-off handshake and the bookkeeping.
  int unsigned  sender_idle_pct   = 0;
  int unsigned  receiver_idle_pct = 0;
  int unsigned  hold_requests     = 0;
  int unsigned  hold_served       = 0;
  int unsigned  hold_left         = 0;
  int unsigned  idle_cycles       = 0;
  int unsigned  mismatches        = 0;
  int unsigned  ops_accepted      = 0;
  int unsigned  words_popped      = 0;
  int unsigned  pushes_refused    = 0;
  int unsigned  pops_refused      = 0;
  int unsigned  slot_settings     = 0;

  circular_deque u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .out_status (out_status),
    .out_count  (out_count)
  );

  always #4 clk = ~clk;

  // The slot register is clamped to at least two and at most the capped store depth.
  function automatic int unsigned usable_slots();
    int unsigned n;
    n = mirror_slots;
    if (n < 2) n = 2;
    if (n > cdq_pkg::CAP) n = cdq_pkg::CAP;
    return n;
  endfunction

  // Applies one operation to the mirror and returns the result the block must give for it.
  // The front pointer sits on the empty slot before the first word, the rear pointer on the
  // last word, and the deque is empty when they meet.
  function automatic deque_res_t apply_deque_op(deque_op_t op);
    deque_res_t   res;
    int unsigned  n;
    int unsigned  f;
    int unsigned  r;
    n = usable_slots();
    f = mirror_front % n;
    r = mirror_rear % n;
    res.data   = cdq_pkg::DATA_NONE;
    res.status = cdq_pkg::ST_DONE;
    case (op.act)
      cdq_pkg::ACT_PUSH_REAR: begin
        if ((r + 1) % n == f) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          r = (r + 1) % n;
          mirror_words[r] = op.val;
        end
      end
      cdq_pkg::ACT_PUSH_FRONT: begin
        // The word goes into the empty slot, and the front then steps back with wraparound.
        if ((r + 1) % n == f) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          mirror_words[f] = op.val;
          f = (f + n - 1) % n;
        end
      end
      cdq_pkg::ACT_POP_FRONT: begin
        if (f == r) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          f = (f + 1) % n;
          res.data = mirror_words[f];
        end
      end
      default: begin
        // Pop at the rear reads the last word, then the rear steps back with wraparound.
        if (f == r) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          res.data = mirror_words[r];
          r = (r + n - 1) % n;
        end
      end
    endcase
    mirror_front = f;
    mirror_rear  = r;
    res.count    = cdq_pkg::cnt_t'((r + n - f) % n);
    return res;
  endfunction

  // Driver: predicts the result of each accepted beat at the edge that accepts it, then
  // offers the next queued operation or idles. A stalled beat is held unchanged.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        owed_results.push_back(apply_deque_op(offered_op));
        ops_accepted++;
        case (owed_results[$].status)
          cdq_pkg::ST_FULL:  pushes_refused++;
          cdq_pkg::ST_EMPTY: pops_refused++;
          default: begin
            if (offered_op.act inside {cdq_pkg::ACT_POP_FRONT, cdq_pkg::ACT_POP_REAR})
              words_popped++;
          end
        endcase
      end
      if (!in_valid || !in_stall) begin
        if (queued_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_op = queued_ops.pop_front();
          in_valid  <= 1'b1;
          in_action <= offered_op.act;
          in_value  <= offered_op.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest owed result and drives the stall.
  // A hold-off request from the stimulus is served here by counting its cycles down.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Unexpected result at %0t: data %0d status %0d count %0d",
                     $time, out_data, out_status, out_count);
        end else if (out_data !== owed_results[0].data ||
                     out_status !== owed_results[0].status ||
                     out_count !== owed_results[0].count) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("Mismatch at %0t: expected data %0d status %0d count %0d,",
                     $time, owed_results[0].data, owed_results[0].status,
                     owed_results[0].count);
            $display("  got data %0d status %0d count %0d",
                     out_data, out_status, out_count);
          end
          void'(owed_results.pop_front());
        end else begin
          void'(owed_results.pop_front());
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // Watchdog: counts cycles without any beat while work is still outstanding.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (queued_ops.size() != 0 || owed_results.size() != 0 || in_valid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired at %0t with %0d results outstanding", $time,
                 owed_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic queue_op(cdq_pkg::action_t act, logic signed [cdq_pkg::DATA_W-1:0] val);
    deque_op_t op;
    op.act = act;
    op.val = val;
    queued_ops.push_back(op);
  endtask

  // Waits until every operation has been offered and every owed result has arrived. Every
  // beat yields a result, so nothing is left in flight after a short margin.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (queued_ops.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // Writes the slot register while the block is idle; the mirror is emptied in step.
  task automatic write_slots(logic [cdq_pkg::SLOT_W-1:0] setting);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= setting;
    mirror_slots = setting;
    mirror_front = 0;
    mirror_rear  = 0;
    slot_settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly full-range random words, with the corner values mixed in.
  function automatic logic signed [cdq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return cdq_pkg::DATA_NONE;
      default: return $urandom;
    endcase
  endfunction

  // Random operations in runs: filling runs drive the deque to full, draining runs to empty,
  // and mixed runs wander in between. Run lengths scale with the slot count.
  task automatic queue_random_ops(int unsigned total, int unsigned span);
    int unsigned left;
    int unsigned run;
    int unsigned push_pct;
    left = total;
    while (left != 0) begin
      case ($urandom_range(2))
        0:       push_pct = 90;
        1:       push_pct = 10;
        default: push_pct = 50;
      endcase
      run = $urandom_range(2 * span, 1);
      if (run > left) run = left;
      left -= run;
      repeat (run) begin
        if ($urandom_range(99) < push_pct)
          queue_op($urandom_range(1) ? cdq_pkg::ACT_PUSH_FRONT : cdq_pkg::ACT_PUSH_REAR,
                   pick_word());
        else
          queue_op($urandom_range(1) ? cdq_pkg::ACT_POP_REAR : cdq_pkg::ACT_POP_FRONT,
                   $urandom);
      end
    end
  endtask

  initial begin : stimulus
    logic [cdq_pkg::SLOT_W-1:0] slot_plan [PHASES];
    slot_plan = '{5'd31, 5'd5, 5'd0, 5'd16, 5'd1, 5'd9, 5'd2, 5'd17, 5'd3,
                  5'($urandom_range(31)), 5'd12, 5'($urandom_range(31))};
    foreach (mirror_words[i]) mirror_words[i] = '0;
    mirror_front = 0;
    mirror_rear  = 0;
    mirror_slots = cdq_pkg::SLOTS_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct   = 21;
    receiver_idle_pct = 63;

    // Directed part at the reset slot count: refused pops on an empty deque, pushes of the
    // extreme words at both ends, with the front wrapping below slot zero, then pops back to
    // empty from both ends.
    queue_op(cdq_pkg::ACT_POP_FRONT, $urandom);
    queue_op(cdq_pkg::ACT_POP_REAR, $urandom);
    queue_op(cdq_pkg::ACT_PUSH_REAR, 32'sh7FFF_FFFF);
    queue_op(cdq_pkg::ACT_PUSH_FRONT, 32'sh8000_0000);
    queue_op(cdq_pkg::ACT_PUSH_REAR, '0);
    queue_op(cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::DATA_NONE);
    queue_op(cdq_pkg::ACT_POP_FRONT, $urandom);
    queue_op(cdq_pkg::ACT_POP_REAR, $urandom);
    queue_op(cdq_pkg::ACT_POP_REAR, $urandom);
    queue_op(cdq_pkg::ACT_POP_FRONT, $urandom);
    queue_op(cdq_pkg::ACT_POP_FRONT, $urandom);
    wait_until_drained();

    // Smallest deque, one word: refused pushes at both ends, and a rear pop that wraps the
    // rear below slot zero.
    write_slots(cdq_pkg::SLOTS_MIN);
    queue_op(cdq_pkg::ACT_PUSH_FRONT, 32'sh5555_5555);
    queue_op(cdq_pkg::ACT_PUSH_REAR, $urandom);
    queue_op(cdq_pkg::ACT_PUSH_FRONT, $urandom);
    queue_op(cdq_pkg::ACT_POP_REAR, $urandom);
    queue_op(cdq_pkg::ACT_PUSH_REAR, 32'shAAAA_AAAA);
    queue_op(cdq_pkg::ACT_POP_FRONT, $urandom);
    queue_op(cdq_pkg::ACT_POP_REAR, $urandom);
    wait_until_drained();

    // Random phases, each at its own slot setting. The idling pattern changes after each
    // third of the run; two phases open with a long hold-off on the result channel so that
    // the block backs up and stalls its input.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES / 3) begin
        sender_idle_pct   = 63;
        receiver_idle_pct = 21;
      end else if (phase == 2 * PHASES / 3) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      write_slots(slot_plan[phase]);
      if (phase == 3 || phase == 10) hold_requests++;
      queue_random_ops(OPS_PER_PHASE, usable_slots());
      wait_until_drained();
    end

    // Keep the clock running to catch any stray result beat.
    repeat (10) @(posedge clk);

    $display("Ran %0d operations over %0d slot settings with idling on both channels.",
             ops_accepted, slot_settings);
    $display("Pops returned %0d words; %0d pushes refused as full, %0d pops refused as empty.",
             words_popped, pushes_refused, pops_refused);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, owed_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
